// ----- rtl/core/ehd_pkg.sv -----
// ============================================================================
// Extendible hash directory package
// Shared constants, codes and a helper function of the directory block.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package ehd_pkg;

   localparam int MAX_DEPTH    = 10;
   localparam int PAGE_ID_BITS = 16;
   localparam int ADDR_BITS    = MAX_DEPTH;
   localparam int DIR_SLOTS    = 1 << MAX_DEPTH;
   localparam int DEPTH_BITS   = 4;
   localparam int KEY_BITS     = 10;
   localparam int CSR_IDX_BITS = 1;
   localparam int CSR_DATA_BITS = 4;

   localparam logic [CSR_IDX_BITS-1:0] CSR_INITIAL_DEPTH   = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INTERLEAVE_MODE = 1'b1;

   typedef enum logic [1:0] {
      OP_GET    = 2'd0,
      OP_SET    = 2'd1,
      OP_DOUBLE = 2'd2,
      OP_INIT   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_RANGE   = 2'd1,
      STATUS_FULL    = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GET,
      ST_COPY,
      ST_DRAIN,
      ST_FILL
   } state_type;

   // Mask of the live index bits for a directory of 2^depth entries.
   function automatic logic [ADDR_BITS-1:0] live_mask(input logic [DEPTH_BITS-1:0] depth);
      live_mask = ~({ADDR_BITS{1'b1}} << depth);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ehd_if.sv -----
// ============================================================================
// Extendible hash directory channels
// Request and response channels with valid/ready handshake.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface ehd_req_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        opcode;
   logic [ehd_pkg::KEY_BITS-1:0]      hash_key;
   logic [ehd_pkg::PAGE_ID_BITS-1:0]  page_id_in;

   modport source (output valid, output opcode, output hash_key, output page_id_in,
                   input ready);
   modport sink   (input valid, input opcode, input hash_key, input page_id_in,
                   output ready);
endinterface

interface ehd_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [ehd_pkg::PAGE_ID_BITS-1:0]  page_id_out;
   logic [ehd_pkg::DEPTH_BITS-1:0]    global_depth;
   logic [1:0]                        status;

   modport source (output valid, output page_id_out, output global_depth, output status,
                   input ready);
   modport sink   (input valid, input page_id_out, input global_depth, input status,
                   output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ehd_ram.sv -----
// ============================================================================
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ehd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/extendible_hash_directory.sv -----
// ============================================================================
// Extendible hash directory
// Directory of an extendible hash table held in one synchronous RAM.
// ============================================================================
// A set writes the directory RAM in the cycle it is accepted; a get answers
// from the registered RAM read data. An init walks the 2^depth live entries,
// a double the live entries in append mode or all 2^(depth+1) entries in
// interleave mode, through the single RAM write port, one entry per cycle.
// One request is in flight at a time; the response register lets the next
// request be accepted in the cycle its predecessor's response is taken.
`timescale 1ns / 1ps
`default_nettype none

module extendible_hash_directory (
   input  wire logic                               clock,
   input  wire logic                               reset,
   ehd_req_if.sink                                 req_ch,
   ehd_rsp_if.source                               rsp_ch,
   input  wire logic                               csr_write_enable,
   input  wire logic [ehd_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [ehd_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   ehd_pkg::state_type                     state_ff, state_in;
   logic [ehd_pkg::DEPTH_BITS-1:0]         depth_ff, depth_in;
   logic [ehd_pkg::DEPTH_BITS-1:0]         init_depth_ff;
   logic                                   interleave_ff;
   logic [ehd_pkg::ADDR_BITS-1:0]          cnt_ff, cnt_in;
   logic                                   wr_pending_ff, wr_pending_in;
   logic [ehd_pkg::ADDR_BITS-1:0]          wr_addr_ff, wr_addr_in;

   logic                                   rsp_valid_ff;
   logic [ehd_pkg::PAGE_ID_BITS-1:0]       rsp_page_ff;
   logic [ehd_pkg::DEPTH_BITS-1:0]         rsp_depth_ff;
   ehd_pkg::status_type                    rsp_status_ff;
   logic                                   rsp_load;
   logic [ehd_pkg::PAGE_ID_BITS-1:0]       rsp_page_in;
   logic [ehd_pkg::DEPTH_BITS-1:0]         rsp_depth_in;
   ehd_pkg::status_type                    rsp_status_in;

   logic                                   ram_wr_en;
   logic [ehd_pkg::ADDR_BITS-1:0]          ram_wr_addr;
   logic [ehd_pkg::PAGE_ID_BITS-1:0]       ram_wr_data;
   logic                                   ram_rd_en;
   logic [ehd_pkg::ADDR_BITS-1:0]          ram_rd_addr;
   logic [ehd_pkg::PAGE_ID_BITS-1:0]       ram_rd_data;

   logic                                   accept;
   logic                                   key_ok;
   logic [ehd_pkg::ADDR_BITS-1:0]          mask_now;
   logic [ehd_pkg::ADDR_BITS-1:0]          live_now;
   logic [ehd_pkg::DEPTH_BITS-1:0]         depth_next;
   logic [ehd_pkg::DEPTH_BITS-1:0]         init_clamped;
   ehd_pkg::opcode_type                    req_op;

   assign req_op       = ehd_pkg::opcode_type'(req_ch.opcode);
   assign mask_now     = ehd_pkg::live_mask(depth_ff);
   assign live_now     = mask_now + ehd_pkg::ADDR_BITS'(1);
   assign depth_next   = depth_ff + ehd_pkg::DEPTH_BITS'(1);
   assign init_clamped = (init_depth_ff > ehd_pkg::DEPTH_BITS'(ehd_pkg::MAX_DEPTH))
                         ? ehd_pkg::DEPTH_BITS'(ehd_pkg::MAX_DEPTH) : init_depth_ff;
   assign key_ok       = (req_ch.hash_key & ~mask_now) == '0;

   assign req_ch.ready = (state_ff == ehd_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign accept       = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         init_depth_ff <= '0;
         interleave_ff <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            ehd_pkg::CSR_INITIAL_DEPTH: begin
               init_depth_ff <= csr_data;
            end
            ehd_pkg::CSR_INTERLEAVE_MODE: begin
               interleave_ff <= csr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ehd_pkg::ST_IDLE;
         depth_ff      <= '0;
         wr_pending_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         depth_ff      <= depth_in;
         wr_pending_ff <= wr_pending_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      wr_addr_ff <= wr_addr_in;
      if (rsp_load) begin
         rsp_page_ff   <= rsp_page_in;
         rsp_depth_ff  <= rsp_depth_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      depth_in      = depth_ff;
      cnt_in        = cnt_ff;
      wr_pending_in = 1'b0;
      wr_addr_in    = wr_addr_ff;
      rsp_load      = 1'b0;
      rsp_page_in   = '0;
      rsp_depth_in  = depth_ff;
      rsp_status_in = ehd_pkg::STATUS_OK;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = req_ch.hash_key;

      unique case (state_ff)
         ehd_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  ehd_pkg::OP_GET: begin
                     if (key_ok) begin
                        ram_rd_en = 1'b1;
                        state_in  = ehd_pkg::ST_GET;
                     end else begin
                        rsp_load      = 1'b1;
                        rsp_status_in = ehd_pkg::STATUS_RANGE;
                     end
                  end
                  ehd_pkg::OP_SET: begin
                     rsp_load      = 1'b1;
                     rsp_status_in = key_ok ? ehd_pkg::STATUS_OK : ehd_pkg::STATUS_RANGE;
                  end
                  ehd_pkg::OP_DOUBLE: begin
                     if (depth_ff >= ehd_pkg::DEPTH_BITS'(ehd_pkg::MAX_DEPTH)) begin
                        rsp_load      = 1'b1;
                        rsp_status_in = ehd_pkg::STATUS_FULL;
                     end else begin
                        cnt_in   = interleave_ff ? ehd_pkg::live_mask(depth_next) : '0;
                        state_in = ehd_pkg::ST_COPY;
                     end
                  end
                  ehd_pkg::OP_INIT: begin
                     depth_in = init_clamped;
                     cnt_in   = '0;
                     state_in = ehd_pkg::ST_FILL;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ehd_pkg::ST_GET: begin
            rsp_load    = 1'b1;
            rsp_page_in = ram_rd_data;
            state_in    = ehd_pkg::ST_IDLE;
         end
         ehd_pkg::ST_COPY: begin
            ram_rd_en     = 1'b1;
            wr_pending_in = 1'b1;
            if (interleave_ff) begin
               ram_rd_addr = cnt_ff >> 1;
               wr_addr_in  = cnt_ff;
               cnt_in      = cnt_ff - ehd_pkg::ADDR_BITS'(1);
               if (cnt_ff == '0) begin
                  state_in = ehd_pkg::ST_DRAIN;
               end
            end else begin
               ram_rd_addr = cnt_ff;
               wr_addr_in  = cnt_ff + live_now;
               cnt_in      = cnt_ff + ehd_pkg::ADDR_BITS'(1);
               if (cnt_ff == mask_now) begin
                  state_in = ehd_pkg::ST_DRAIN;
               end
            end
         end
         ehd_pkg::ST_DRAIN: begin
            depth_in     = depth_next;
            rsp_load     = 1'b1;
            rsp_depth_in = depth_next;
            state_in     = ehd_pkg::ST_IDLE;
         end
         ehd_pkg::ST_FILL: begin
            cnt_in = cnt_ff + ehd_pkg::ADDR_BITS'(1);
            if (cnt_ff == mask_now) begin
               rsp_load = 1'b1;
               state_in = ehd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ehd_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = req_ch.hash_key;
      ram_wr_data = req_ch.page_id_in;
      if (wr_pending_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = wr_addr_ff;
         ram_wr_data = ram_rd_data;
      end else if (state_ff == ehd_pkg::ST_FILL) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = cnt_ff;
         ram_wr_data = ehd_pkg::PAGE_ID_BITS'(cnt_ff);
      end else if (accept && req_op == ehd_pkg::OP_SET && key_ok) begin
         ram_wr_en = 1'b1;
      end
   end

   ehd_ram #(
      .WIDTH (ehd_pkg::PAGE_ID_BITS),
      .DEPTH (ehd_pkg::DIR_SLOTS)
   ) u_dir_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.page_id_out  = rsp_page_ff;
   assign rsp_ch.global_depth = rsp_depth_ff;
   assign rsp_ch.status       = rsp_status_ff;

endmodule

`default_nettype wire

// ----- rtl/core/ehd_checker.sv -----
// ============================================================================
// Extendible hash directory checker
// Port-level assertions on the response channel, bound to the top level.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ehd_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic [ehd_pkg::PAGE_ID_BITS-1:0]   rsp_page_id_out,
   input wire logic [ehd_pkg::DEPTH_BITS-1:0]     rsp_global_depth,
   input wire logic [1:0]                         rsp_status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                  && $stable(rsp_page_id_out))
      else $error("Stalled response changed.");

   a_error_no_page: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ehd_pkg::STATUS_OK |-> rsp_page_id_out == '0)
      else $error("Failed request returned a page id.");

   a_full_at_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ehd_pkg::STATUS_FULL
      |-> rsp_global_depth == ehd_pkg::DEPTH_BITS'(ehd_pkg::MAX_DEPTH))
      else $error("Full status below maximum depth.");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_global_depth <= ehd_pkg::DEPTH_BITS'(ehd_pkg::MAX_DEPTH))
      else $error("Global depth above maximum.");

endmodule

bind extendible_hash_directory ehd_checker u_ehd_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_page_id_out  (rsp_ch.page_id_out),
   .rsp_global_depth (rsp_ch.global_depth),
   .rsp_status       (rsp_ch.status)
);

`default_nettype wire

// ----- bench/ehd_directory_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Extendible hash directory checker
// Watches the request, response and register ports of the directory. It keeps
// its own copy of the page store, the global depth and both settings. For each
// accepted request it predicts the response and compares each response with
// the oldest prediction, field by field. It counts every mismatch for the top.
// ============================================================================

module ehd_directory_checker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   ehd_req_if                                      req_mon,
   ehd_rsp_if                                      rsp_mon,
   input  wire logic                               csr_write_enable,
   input  wire logic [ehd_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [ehd_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output int                                      mismatch_total,
   output int                                      replies_outstanding
);

   typedef struct packed {
      logic [ehd_pkg::PAGE_ID_BITS-1:0] page_id;
      logic [ehd_pkg::DEPTH_BITS-1:0]   depth;
      ehd_pkg::status_type              status;
   } dir_reply_type;

   logic [ehd_pkg::PAGE_ID_BITS-1:0] page_store [0:ehd_pkg::DIR_SLOTS-1];
   int                               global_depth_q;
   logic [3:0]                       init_depth_cfg;
   logic                             interleave_cfg;
   dir_reply_type                    replies_due [$];

   function automatic dir_reply_type apply_directory_op(
      input ehd_pkg::opcode_type              op,
      input logic [ehd_pkg::KEY_BITS-1:0]     key,
      input logic [ehd_pkg::PAGE_ID_BITS-1:0] page);
      dir_reply_type reply;
      int            live;
      int            target;
      int            i;
      reply.page_id = '0;
      reply.status = ehd_pkg::STATUS_OK;
      live = 1 << global_depth_q;
      case (op)
         ehd_pkg::OP_GET: begin
            if (int'(key) < live) reply.page_id = page_store[key];
            else reply.status = ehd_pkg::STATUS_RANGE;
         end
         ehd_pkg::OP_SET: begin
            if (int'(key) < live) page_store[key] = page;
            else reply.status = ehd_pkg::STATUS_RANGE;
         end
         ehd_pkg::OP_DOUBLE: begin
            if (global_depth_q >= ehd_pkg::MAX_DEPTH) begin
               reply.status = ehd_pkg::STATUS_FULL;
            end else begin
               if (interleave_cfg) begin
                  for (i = 2 * live - 1; i >= 0; i--) page_store[i] = page_store[i >> 1];
               end else begin
                  for (i = 0; i < live; i++) page_store[i + live] = page_store[i];
               end
               global_depth_q++;
            end
         end
         default: begin
            target = (init_depth_cfg > ehd_pkg::MAX_DEPTH) ? ehd_pkg::MAX_DEPTH
                                                           : int'(init_depth_cfg);
            for (i = 0; i < (1 << target); i++) page_store[i] = ehd_pkg::PAGE_ID_BITS'(i);
            global_depth_q = target;
         end
      endcase
      reply.depth = ehd_pkg::DEPTH_BITS'(global_depth_q);
      return reply;
   endfunction

   always @(posedge clock) begin
      dir_reply_type due;
      if (reset) begin
         global_depth_q = 0;
         init_depth_cfg = '0;
         interleave_cfg = 1'b0;
         replies_due.delete();
         mismatch_total = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (replies_due.size() == 0) begin
               $display("%0t: response with no request pending: page %h depth %0d status %0d",
                        $time, rsp_mon.page_id_out, rsp_mon.global_depth, rsp_mon.status);
               mismatch_total++;
            end else begin
               due = replies_due.pop_front();
               if (rsp_mon.page_id_out !== due.page_id) begin
                  $display("%0t: page_id_out mismatch: expected %h, actual %h",
                           $time, due.page_id, rsp_mon.page_id_out);
                  mismatch_total++;
               end
               if (rsp_mon.global_depth !== due.depth) begin
                  $display("%0t: global_depth mismatch: expected %0d, actual %0d",
                           $time, due.depth, rsp_mon.global_depth);
                  mismatch_total++;
               end
               if (rsp_mon.status !== due.status) begin
                  $display("%0t: status mismatch: expected %0d, actual %0d",
                           $time, due.status, rsp_mon.status);
                  mismatch_total++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            replies_due.push_back(apply_directory_op(ehd_pkg::opcode_type'(req_mon.opcode),
                                                     req_mon.hash_key, req_mon.page_id_in));
         end
         if (csr_write_enable) begin
            if (csr_index == ehd_pkg::CSR_INITIAL_DEPTH) init_depth_cfg = csr_data[3:0];
            else interleave_cfg = csr_data[0];
         end
      end
      replies_outstanding = replies_due.size();
   end

endmodule

// ----- bench/extendible_hash_directory_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Extendible hash directory testbench
// Drives the directory with a short directed sequence of gets, sets, doublings
// and inits, then with phases of random requests, each phase under its own
// register settings. Both channels stall at random, and once the response side
// holds off long enough to back up the request side. A checker beside the
// block predicts and compares every response; this module gives the verdict.
// ============================================================================

module extendible_hash_directory_tb;

   localparam int QUIET_LIMIT    = 20000;
   localparam int PHASES         = 12;
   localparam int PHASE_REQUESTS = 155;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              csr_write_enable = 1'b0;
   logic [ehd_pkg::CSR_IDX_BITS-1:0]  csr_index = ehd_pkg::CSR_INITIAL_DEPTH;
   logic [ehd_pkg::CSR_DATA_BITS-1:0] csr_data = '0;

   ehd_req_if req_ch ();
   ehd_rsp_if rsp_ch ();

   int         mismatch_total;
   int         replies_outstanding;
   int         requests_sent = 0;
   int         responses_seen = 0;
   int         quiet_cycles = 0;
   bit         idling_on = 1'b1;
   bit         long_hold_done = 1'b0;
   int         depth_shadow = 0;
   logic [3:0] init_depth_setting = '0;
   logic       interleave_setting = 1'b0;
   bit         key_written [0:ehd_pkg::DIR_SLOTS-1];

   extendible_hash_directory u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   ehd_directory_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_mon             (req_ch),
      .rsp_mon             (rsp_ch),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .mismatch_total      (mismatch_total),
      .replies_outstanding (replies_outstanding)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) responses_seen <= responses_seen + 1;
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no request or response accepted for %0d cycles", $time, QUIET_LIMIT);
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // The response side stalls in short bursts, and once for a long stretch.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!long_hold_done && responses_seen >= 300) begin
            long_hold_done = 1'b1;
            stall_left = 200;
         end
         if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 13) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Tracks which entries hold a written value, so that no get reads one that was never written.
   task automatic send_request(input ehd_pkg::opcode_type op,
                               input logic [ehd_pkg::KEY_BITS-1:0] key,
                               input logic [ehd_pkg::PAGE_ID_BITS-1:0] page);
      int live;
      int target;
      int i;
      live = 1 << depth_shadow;
      case (op)
         ehd_pkg::OP_SET: begin
            if (int'(key) < live) key_written[key] = 1'b1;
         end
         ehd_pkg::OP_DOUBLE: begin
            if (depth_shadow < ehd_pkg::MAX_DEPTH) begin
               if (interleave_setting) begin
                  for (i = 2 * live - 1; i >= 0; i--) key_written[i] = key_written[i >> 1];
               end else begin
                  for (i = 0; i < live; i++) key_written[i + live] = key_written[i];
               end
               depth_shadow++;
            end
         end
         ehd_pkg::OP_INIT: begin
            target = (init_depth_setting > ehd_pkg::MAX_DEPTH) ? ehd_pkg::MAX_DEPTH
                                                               : int'(init_depth_setting);
            for (i = 0; i < (1 << target); i++) key_written[i] = 1'b1;
            depth_shadow = target;
         end
         default: begin
         end
      endcase
      req_ch.valid <= 1'b1;
      req_ch.opcode <= op;
      req_ch.hash_key <= key;
      req_ch.page_id_in <= page;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      requests_sent++;
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   task automatic apply_settings(input logic [3:0] depth_cfg, input logic interleave);
      req_ch.valid <= 1'b0;
      while (responses_seen != requests_sent) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= ehd_pkg::CSR_INITIAL_DEPTH;
      csr_data <= ehd_pkg::CSR_DATA_BITS'(depth_cfg);
      @(posedge clock);
      csr_index <= ehd_pkg::CSR_INTERLEAVE_MODE;
      csr_data <= {{(ehd_pkg::CSR_DATA_BITS-1){1'b0}}, interleave};
      @(posedge clock);
      csr_write_enable <= 1'b0;
      init_depth_setting = depth_cfg;
      interleave_setting = interleave;
   endtask

   task automatic send_random_request(input int depth_cap);
      ehd_pkg::opcode_type          op;
      logic [ehd_pkg::KEY_BITS-1:0] key;
      int                           live;
      int                           pick;
      live = 1 << depth_shadow;
      pick = $urandom_range(0, 99);
      key = ehd_pkg::KEY_BITS'($urandom_range(0, live - 1));
      if (live < ehd_pkg::DIR_SLOTS && $urandom_range(0, 11) == 0) begin
         key = ehd_pkg::KEY_BITS'($urandom_range(live, ehd_pkg::DIR_SLOTS - 1));
      end
      if (pick < 40) op = ehd_pkg::OP_GET;
      else if (pick < 76) op = ehd_pkg::OP_SET;
      else if (pick < 94) begin
         op = (depth_shadow < depth_cap || depth_shadow == ehd_pkg::MAX_DEPTH)
              ? ehd_pkg::OP_DOUBLE : ehd_pkg::OP_GET;
      end else op = ehd_pkg::OP_INIT;
      if (op == ehd_pkg::OP_GET && int'(key) < live && !key_written[key]) op = ehd_pkg::OP_SET;
      send_request(op, key, ehd_pkg::PAGE_ID_BITS'($urandom));
   endtask

   initial begin
      int         phase;
      int         depth_cap;
      logic [3:0] depth_cfg;
      logic       interleave;
      req_ch.valid = 1'b0;
      req_ch.opcode = ehd_pkg::OP_GET;
      req_ch.hash_key = '0;
      req_ch.page_id_in = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(ehd_pkg::OP_GET, 10'd1, 16'h1234);
      send_request(ehd_pkg::OP_GET, 10'd1023, 16'hFFFF);
      send_request(ehd_pkg::OP_SET, 10'd1023, 16'h0001);
      send_request(ehd_pkg::OP_SET, 10'd0, 16'hFFFF);
      send_request(ehd_pkg::OP_GET, 10'd0, 16'h0000);
      send_request(ehd_pkg::OP_DOUBLE, 10'd0, 16'h0000);
      send_request(ehd_pkg::OP_GET, 10'd1, 16'h0000);
      send_request(ehd_pkg::OP_SET, 10'd1, 16'h0000);
      send_request(ehd_pkg::OP_GET, 10'd1, 16'hFFFF);
      send_request(ehd_pkg::OP_INIT, 10'd0, 16'h0000);
      send_request(ehd_pkg::OP_GET, 10'd0, 16'h0000);

      apply_settings(4'd15, 1'b1);
      send_request(ehd_pkg::OP_INIT, 10'd1023, 16'hFFFF);
      send_request(ehd_pkg::OP_DOUBLE, 10'd0, 16'h0000);
      send_request(ehd_pkg::OP_GET, 10'd1023, 16'h0000);
      send_request(ehd_pkg::OP_SET, 10'd1023, 16'hA5A5);
      send_request(ehd_pkg::OP_GET, 10'd1023, 16'h0000);
      send_request(ehd_pkg::OP_SET, 10'd0, 16'h5A5A);
      send_request(ehd_pkg::OP_GET, 10'd512, 16'h0000);
      send_request(ehd_pkg::OP_GET, 10'd0, 16'h0000);

      apply_settings(4'd2, 1'b1);
      send_request(ehd_pkg::OP_INIT, 10'd0, 16'h0000);
      send_request(ehd_pkg::OP_SET, 10'd3, 16'hBEEF);
      send_request(ehd_pkg::OP_DOUBLE, 10'd0, 16'h0000);
      send_request(ehd_pkg::OP_GET, 10'd7, 16'h0000);
      send_request(ehd_pkg::OP_GET, 10'd6, 16'h0000);
      send_request(ehd_pkg::OP_GET, 10'd5, 16'h0000);

      for (phase = 0; phase < PHASES; phase++) begin
         idling_on = (phase % 3 != 2) && (phase < PHASES - 2);
         case (phase)
            0: depth_cfg = 4'd0;
            1: depth_cfg = 4'd10;
            default: begin
               if ($urandom_range(0, 11) == 0) depth_cfg = 4'($urandom_range(10, 15));
               else depth_cfg = 4'($urandom_range(0, 5));
            end
         endcase
         interleave = 1'($urandom_range(0, 1));
         apply_settings(depth_cfg, interleave);
         depth_cap = ((depth_cfg > ehd_pkg::MAX_DEPTH) ? ehd_pkg::MAX_DEPTH : int'(depth_cfg))
                     + $urandom_range(1, 3);
         if (depth_cap > ehd_pkg::MAX_DEPTH) depth_cap = ehd_pkg::MAX_DEPTH;
         send_request(ehd_pkg::OP_INIT, ehd_pkg::KEY_BITS'($urandom),
                      ehd_pkg::PAGE_ID_BITS'($urandom));
         repeat (PHASE_REQUESTS) send_random_request(depth_cap);
      end

      req_ch.valid <= 1'b0;
      while (responses_seen != requests_sent) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_total == 0 && replies_outstanding == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
